// ===== rtl/cqrk_pkg.sv =====
// Shared types and constants for the circular queue with keyed removal.
`default_nettype none

package cqrk_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int PLATE_W   = 64;
    localparam int SERVICE_W = 8;
    localparam int TIME_W    = 32;
    localparam int OCC_W     = 3;
    localparam int REQ_W     = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    // Read address source for the record store
    typedef enum logic [1:0] {
        RD_HEAD  = 2'd0,
        RD_NEXT  = 2'd1,
        RD_NEXT2 = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic [PLATE_W-1:0]   plate;
        logic [SERVICE_W-1:0] service;
        logic [TIME_W-1:0]    etime;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // Controller to datapath
    typedef struct packed {
        logic    capture;
        logic    push;
        logic    clear;
        logic    pop_adv;
        logic    take_rec;
        logic    scan_start;
        logic    advance;
        logic    shift_write;
        logic    drop_at_pos;
        logic    drop_at_next;
        logic    set_ok;
        logic    load_out;
        rd_sel_t rd_sel;
    } cqrk_cmd_t;

    // Datapath to controller
    typedef struct packed {
        req_t req_type;
        logic empty;
        logic full;
        logic match;
        logic next_is_tail;
        logic next2_is_tail;
        logic last;
    } cqrk_sts_t;

endpackage

`default_nettype wire

// ===== rtl/cqrk_if.sv =====
// Request and response channel interfaces.
`default_nettype none

interface cqrk_req_if import cqrk_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [PLATE_W-1:0]   plate_key;
    logic [SERVICE_W-1:0] service_code;
    logic [TIME_W-1:0]    entry_time;

    modport source (
        output valid, req_type, plate_key, service_code, entry_time,
        input  ready
    );
    modport sink (
        input  valid, req_type, plate_key, service_code, entry_time,
        output ready
    );
endinterface

interface cqrk_rsp_if import cqrk_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 success;
    logic [PLATE_W-1:0]   out_plate;
    logic [SERVICE_W-1:0] out_service;
    logic [TIME_W-1:0]    out_time;
    logic [OCC_W-1:0]     occupancy;
    logic                 is_empty;
    logic                 is_full;

    modport source (
        output valid, success, out_plate, out_service, out_time, occupancy,
               is_empty, is_full,
        input  ready
    );
    modport sink (
        input  valid, success, out_plate, out_service, out_time, occupancy,
               is_empty, is_full,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/cqrk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cqrk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/cqrk_dp.sv =====
// Datapath: ring pointers, record store, scan pointer and response registers.
`default_nettype none

module cqrk_dp import cqrk_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cqrk_cmd_t            cmd,
    output cqrk_sts_t                 sts,
    input  wire logic [REQ_W-1:0]     req_type,
    input  wire logic [PLATE_W-1:0]   plate_key,
    input  wire logic [SERVICE_W-1:0] service_code,
    input  wire logic [TIME_W-1:0]    entry_time,
    output logic                      success,
    output logic [PLATE_W-1:0]        out_plate,
    output logic [SERVICE_W-1:0]      out_service,
    output logic [TIME_W-1:0]         out_time,
    output logic [OCC_W-1:0]          occupancy,
    output logic                      is_empty,
    output logic                      is_full
);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(SLOTS - 1)) ? '0 : p + IDX_W'(1);
    endfunction

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] left_reg, left_next;
    logic             ok_reg, ok_next;
    req_t             req_type_reg, req_type_next;
    rec_t             req_rec_reg, req_rec_next;
    rec_t             rec_reg, rec_next;

    logic                 success_reg, success_next;
    rec_t                 out_rec_reg, out_rec_next;
    logic [OCC_W-1:0]     occ_reg, occ_next;
    logic                 empty_reg, empty_next;
    logic                 full_reg, full_next;

    logic [IDX_W-1:0] pos_n1;
    logic [IDX_W-1:0] pos_n2;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;
    rec_t             wr_rec;
    logic [REC_W-1:0] rd_data;
    rec_t             rd_rec;
    logic             cnt_zero;
    logic             cnt_full;

    assign pos_n1   = ring_next(pos_reg);
    assign pos_n2   = ring_next(pos_n1);
    assign rd_rec   = rec_t'(rd_data);
    assign cnt_zero = (count_reg == '0);
    assign cnt_full = (count_reg == IDX_W'(SLOTS - 1));

    always_comb
    begin
        case (cmd.rd_sel)
            RD_NEXT:  rd_addr = pos_n1;
            RD_NEXT2: rd_addr = pos_n2;
            default:  rd_addr = head_reg;
        endcase
    end

    assign wr_en   = cmd.push | cmd.shift_write;
    assign wr_addr = cmd.push ? tail_reg : pos_reg;
    assign wr_rec  = cmd.push ? req_rec_reg : rd_rec;

    cqrk_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        left_next     = left_reg;
        ok_next       = ok_reg;
        req_type_next = req_type_reg;
        req_rec_next  = req_rec_reg;
        rec_next      = rec_reg;

        if (cmd.capture)
        begin
            req_type_next        = req_t'(req_type);
            req_rec_next.plate   = plate_key;
            req_rec_next.service = service_code;
            req_rec_next.etime   = entry_time;
            rec_next             = '0;
            ok_next              = 1'b0;
        end
        if (cmd.push)
        begin
            tail_next  = ring_next(tail_reg);
            count_next = count_reg + IDX_W'(1);
        end
        if (cmd.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        if (cmd.pop_adv)
        begin
            head_next  = ring_next(head_reg);
            count_next = count_reg - IDX_W'(1);
        end
        if (cmd.scan_start)
        begin
            pos_next  = head_reg;
            left_next = count_reg;
        end
        if (cmd.advance)
        begin
            pos_next  = pos_n1;
            left_next = left_reg - IDX_W'(1);
        end
        if (cmd.shift_write)
        begin
            pos_next = pos_n1;
        end
        if (cmd.drop_at_pos)
        begin
            tail_next  = pos_reg;
            count_next = count_reg - IDX_W'(1);
        end
        if (cmd.drop_at_next)
        begin
            tail_next  = pos_n1;
            count_next = count_reg - IDX_W'(1);
        end
        if (cmd.take_rec)
        begin
            rec_next = rd_rec;
        end
        if (cmd.set_ok)
        begin
            ok_next = 1'b1;
        end
    end

    always_comb
    begin
        success_next = success_reg;
        out_rec_next = out_rec_reg;
        occ_next     = occ_reg;
        empty_next   = empty_reg;
        full_next    = full_reg;
        if (cmd.load_out)
        begin
            success_next = ok_reg;
            out_rec_next = rec_reg;
            occ_next     = OCC_W'(count_reg);
            empty_next   = cnt_zero;
            full_next    = cnt_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        left_reg     <= left_next;
        ok_reg       <= ok_next;
        req_type_reg <= req_type_next;
        req_rec_reg  <= req_rec_next;
        rec_reg      <= rec_next;
        success_reg  <= success_next;
        out_rec_reg  <= out_rec_next;
        occ_reg      <= occ_next;
        empty_reg    <= empty_next;
        full_reg     <= full_next;
    end

    assign sts.req_type      = req_type_reg;
    assign sts.empty         = cnt_zero;
    assign sts.full          = cnt_full;
    assign sts.match         = (rd_rec.plate == req_rec_reg.plate);
    assign sts.next_is_tail  = (pos_n1 == tail_reg);
    assign sts.next2_is_tail = (pos_n2 == tail_reg);
    assign sts.last          = (left_reg == IDX_W'(1));

    assign success     = success_reg;
    assign out_plate   = out_rec_reg.plate;
    assign out_service = out_rec_reg.service;
    assign out_time    = out_rec_reg.etime;
    assign occupancy   = occ_reg;
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;

endmodule

`default_nettype wire

// ===== rtl/cqrk_ctrl.sv =====
// Controller: sequences push, pop, keyed scan and shift, and the response handshake.
`default_nettype none

module cqrk_ctrl import cqrk_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    input  wire cqrk_sts_t sts,
    output cqrk_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP_WAIT,
        ST_SCAN,
        ST_SHIFT,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = RD_HEAD;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_FIN;
                case (sts.req_type)
                    REQ_PUSH:
                    begin
                        if (!sts.full)
                        begin
                            cmd.push   = 1'b1;
                            cmd.set_ok = 1'b1;
                        end
                    end
                    REQ_POP:
                    begin
                        if (!sts.empty)
                        begin
                            state_next = ST_POP_WAIT;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (!sts.empty)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.clear  = 1'b1;
                        cmd.set_ok = 1'b1;
                    end
                endcase
            end
            ST_POP_WAIT:
            begin
                cmd.take_rec = 1'b1;
                cmd.pop_adv  = 1'b1;
                cmd.set_ok   = 1'b1;
                state_next   = ST_FIN;
            end
            ST_SCAN:
            begin
                // prefetch the entry after the one being compared
                cmd.rd_sel = RD_NEXT;
                if (sts.match)
                begin
                    cmd.take_rec = 1'b1;
                    if (sts.next_is_tail)
                    begin
                        cmd.drop_at_pos = 1'b1;
                        cmd.set_ok      = 1'b1;
                        state_next      = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
                else if (sts.last)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                cmd.rd_sel      = RD_NEXT2;
                cmd.shift_write = 1'b1;
                if (sts.next2_is_tail)
                begin
                    cmd.drop_at_next = 1'b1;
                    cmd.set_ok       = 1'b1;
                    state_next       = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/circular_queue_remove_by_key_top.sv =====
// Top level of the circular vehicle-record queue with keyed removal.
`default_nettype none

// Circular FIFO of vehicle records (plate, service code, entry time) held in
// a ring of SLOTS entries, one slot always left empty, so at most SLOTS-1
// records. Each request is a push at the tail, a pop from the head, a removal
// of the oldest record with a given plate (younger records move one slot
// toward the head, order kept), or a clear; every request yields exactly one
// response with success, the popped or removed record (zero otherwise), the
// count after the request (low three bits) and empty/full flags. Requests are
// handled one at a time: req.ready is high only while the block is idle.
// A push, a clear or a refused request goes from decode straight to the
// response state; a pop first waits for the registered read of the head
// record. A removal compares the held records in order from the head and,
// after a match, moves each younger record down one slot in turn, since the
// record store is a single RAM with one read and one write port and
// registered read data. A removal with no match compares every held record.
// The response sits in an output register, so a new request is accepted the
// cycle after the previous response is loaded, even while that response
// still waits for rsp.ready. No clearing pass is needed after reset.

module circular_queue_remove_by_key_top import cqrk_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    cqrk_req_if.sink  req,
    cqrk_rsp_if.source rsp
);

    cqrk_cmd_t cmd;
    cqrk_sts_t sts;

    // Sequence each request and own the response handshake
    cqrk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold pointers, store and response payload
    cqrk_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req.req_type),
        .plate_key    (req.plate_key),
        .service_code (req.service_code),
        .entry_time   (req.entry_time),
        .success      (rsp.success),
        .out_plate    (rsp.out_plate),
        .out_service  (rsp.out_service),
        .out_time     (rsp.out_time),
        .occupancy    (rsp.occupancy),
        .is_empty     (rsp.is_empty),
        .is_full      (rsp.is_full)
    );

endmodule

`default_nettype wire
